// File: sv/ntp_offset_clock_filter_assert.svh
// ============================================================================
// NTP offset clock filter assertion macros
// Shared property forms for the checks at the end of the filter module.
// ============================================================================
`ifndef NTP_OFFSET_CLOCK_FILTER_ASSERT_SVH
`define NTP_OFFSET_CLOCK_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTPF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NTPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ntpf_pkg.sv
// ============================================================================
// ntpf_pkg
// Types and constants shared by the NTP offset clock filter modules.
// ============================================================================
package ntpf_pkg;

    localparam int TIME_W    = 64;
    localparam int LIMIT_W   = 63;
    localparam int TRUST_W   = 4;
    localparam int STRATUM_W = 8;
    localparam int ORDER_W   = 32;
    localparam int ERRS_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Event codes of an input transaction.
    localparam logic [1:0] FUNC_QUERY     = 2'd0;
    localparam logic [1:0] FUNC_REPLY     = 2'd1;
    localparam logic [1:0] FUNC_SEND_FAIL = 2'd2;
    localparam logic [1:0] FUNC_ADDRESS   = 2'd3;

    localparam logic [1:0] LEAP_ALARM = 2'd3;

    // Verdict codes of a result transaction.
    localparam logic [3:0] V_ACCEPT     = 4'd0;
    localparam logic [3:0] V_COOKIE     = 4'd1;
    localparam logic [3:0] V_UNSYNC     = 4'd2;
    localparam logic [3:0] V_TIME_LIMIT = 4'd3;
    localparam logic [3:0] V_NONMONO    = 4'd4;
    localparam logic [3:0] V_NEG_DELAY  = 4'd5;
    localparam logic [3:0] V_QUERY      = 4'd6;
    localparam logic [3:0] V_SEND_FAIL  = 4'd7;
    localparam logic [3:0] V_ADDRESS    = 4'd8;

    // Poll interval classes.
    localparam logic [1:0] CLASS_PATHETIC   = 2'd0;
    localparam logic [1:0] CLASS_AGGRESSIVE = 2'd1;
    localparam logic [1:0] CLASS_NORMAL     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TRUST_INITIAL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRUST_AGGRESSIVE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRUST_MAX        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STRATUM      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT       = 3'd4;

    // Register values after reset.
    localparam logic [TRUST_W-1:0]   TRUST_INITIAL_RST    = 4'd2;
    localparam logic [TRUST_W-1:0]   TRUST_AGGRESSIVE_RST = 4'd8;
    localparam logic [TRUST_W-1:0]   TRUST_MAX_RST        = 4'd10;
    localparam logic [STRATUM_W-1:0] MAX_STRATUM_RST      = 8'd15;
    localparam logic [LIMIT_W-1:0]   TIME_LIMIT_RST       = {LIMIT_W{1'b1}};

    localparam logic [ERRS_W-1:0] ERRS_MAX = {ERRS_W{1'b1}};

    typedef struct packed {
        logic [1:0]                func;
        logic signed [TIME_W-1:0]  local_send_time;
        logic [TIME_W-1:0]         cookie;
        logic signed [TIME_W-1:0]  server_recv_time;
        logic signed [TIME_W-1:0]  server_send_time;
        logic signed [TIME_W-1:0]  local_recv_time;
        logic [1:0]                leap;
        logic [STRATUM_W-1:0]      stratum;
        logic                      adjust_ok;
    } t_cmd;

    typedef struct packed {
        logic [3:0]                verdict;
        logic signed [TIME_W-1:0]  offset;
        logic signed [TIME_W-1:0]  delay;
        logic [1:0]                interval_class;
        logic [TRUST_W-1:0]        trust;
        logic                      update_valid;
        logic signed [TIME_W-1:0]  update_offset;
        logic signed [TIME_W-1:0]  update_delay;
        logic [STRATUM_W-1:0]      update_stratum;
        logic [ERRS_W-1:0]         send_errors;
    } t_result;

    // Ring entry, split over the two sample memories.
    typedef struct packed {
        logic signed [TIME_W-1:0] offset;
        logic signed [TIME_W-1:0] delay;
    } t_od;

    typedef struct packed {
        logic [STRATUM_W-1:0] stratum;
        logic [ORDER_W-1:0]   order;
    } t_so;

    typedef struct packed {
        logic od;
        logic so;
    } t_ring_we;

    typedef struct packed {
        logic capture;
        logic first;
    } t_scan_ctl;

endpackage

// File: sv/ntp_offset_clock_filter.sv
// ============================================================================
// ntp_offset_clock_filter
// States from the accepting edge to the result strobe: DIFF, DONE for a query,
// send failure, address change or screened-out reply; DIFF, SUM, WRITE, DONE
// for a reply stored while the ring is not yet full (or with negative delay);
// with a full ring, SCAN and INVAL follow WRITE, as the best-sample scan reads
// the sample memory through its single read port, one slot per cycle. A new
// transaction may start in the strobe cycle. Reset (synchronous, active low)
// clears the valid bits, counters, trust, saved query and registers; the sample
// memories are not cleared, since a slot is only read once it is valid.
// ============================================================================
`include "ntp_offset_clock_filter_assert.svh"

module ntp_offset_clock_filter #(
    parameter int RING_DEPTH = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  ntpf_pkg::t_cmd                     i_cmd,
    output logic                               o_strobe,
    output ntpf_pkg::t_result                  o_result,
    input  logic                               i_cfg_we,
    input  logic [ntpf_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [ntpf_pkg::LIMIT_W-1:0]       i_cfg_wdata
);
    import ntpf_pkg::*;

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIFF  = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_INVAL = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]            r_state;
    logic [2:0]            n_state;

    // Configuration registers.
    logic [TRUST_W-1:0]    r_trust_initial;
    logic [TRUST_W-1:0]    r_trust_aggressive;
    logic [TRUST_W-1:0]    r_trust_max;
    logic [STRATUM_W-1:0]  r_max_stratum;
    logic [LIMIT_W-1:0]    r_time_limit;

    // Filter state kept in flip-flops.
    logic [TIME_W-1:0]     r_saved_send;
    logic [TIME_W-1:0]     r_saved_cookie;
    logic [ERRS_W-1:0]     r_errs;
    logic [TRUST_W-1:0]    r_trust;
    logic [IDX_W-1:0]      r_wslot;
    logic [ORDER_W-1:0]    r_arrival;
    logic [RING_DEPTH-1:0] r_valid;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_strobe;

    // Transaction payload and intermediate arithmetic.
    t_cmd                  r_in;
    logic [TIME_W-1:0]     r_d21;
    logic [TIME_W-1:0]     r_d34;
    logic [TIME_W-1:0]     r_d41;
    logic [TIME_W-1:0]     r_d32;
    logic [TIME_W-1:0]     r_sum;
    logic [TIME_W-1:0]     r_dly;
    logic [TIME_W-1:0]     r_res_off;
    logic [TIME_W-1:0]     r_res_dly;
    logic [1:0]            r_iclass;
    logic [3:0]            r_verdict;
    logic                  r_upd;
    t_result               r_out;

    logic                  cookie_bad;
    logic                  unsynced;
    logic                  too_late;
    logic                  nonmono;
    logic                  reply_ok;
    logic [3:0]            diff_verdict;
    logic [TIME_W-1:0]     sum_adj;
    logic [TIME_W-1:0]     off_half;
    logic                  dly_neg;
    logic [RING_DEPTH-1:0] valid_set;
    logic                  ring_full;
    logic [IDX_W-1:0]      wslot_next;
    logic [1:0]            iclass;
    logic                  scan_last;

    t_ring_we              ring_we;
    t_od                   ring_od_wdata;
    t_so                   ring_so_wdata;
    logic [IDX_W-1:0]      ring_raddr;
    t_od                   ring_od_rdata;
    t_so                   ring_so_rdata;
    t_scan_ctl             scan_ctl;
    logic [IDX_W-1:0]      scan_idx;
    t_od                   best_od;
    t_so                   best_so;
    logic [RING_DEPTH-1:0] kill;

    // ------------------------------------------------------------------
    // Reply screening. The checks run in priority order: cookie, then the
    // synchronization state of the server, then bogus server timestamps,
    // then a destination time that does not follow the send time. The
    // negative-delay check comes later, once the delay has been formed.
    // ------------------------------------------------------------------
    assign cookie_bad = (r_in.cookie != r_saved_cookie);
    assign unsynced   = (r_in.leap == LEAP_ALARM) || (r_in.stratum == '0) ||
                        (r_in.stratum > r_max_stratum);
    assign too_late   = ($signed({1'b0, r_time_limit}) < r_in.server_recv_time) ||
                        ($signed({1'b0, r_time_limit}) < r_in.server_send_time);
    assign nonmono    = !($signed(r_saved_send) < r_in.local_recv_time);
    assign reply_ok   = !(cookie_bad || unsynced || too_late || nonmono);

    always_comb begin
        diff_verdict = V_ACCEPT;
        unique case (r_in.func)
            FUNC_QUERY:     diff_verdict = V_QUERY;
            FUNC_SEND_FAIL: diff_verdict = V_SEND_FAIL;
            FUNC_ADDRESS:   diff_verdict = V_ADDRESS;
            FUNC_REPLY: begin
                if (cookie_bad) begin
                    diff_verdict = V_COOKIE;
                end else if (unsynced) begin
                    diff_verdict = V_UNSYNC;
                end else if (too_late) begin
                    diff_verdict = V_TIME_LIMIT;
                end else if (nonmono) begin
                    diff_verdict = V_NONMONO;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sample arithmetic. All differences wrap modulo 2^64. The offset is the
    // wrapped sum halved toward zero: adding the sign bit before the
    // arithmetic shift turns the shift's rounding toward minus infinity into
    // truncation for negative sums.
    // ------------------------------------------------------------------
    assign sum_adj  = r_sum + {{(TIME_W-1){1'b0}}, r_sum[TIME_W-1]};
    assign off_half = {sum_adj[TIME_W-1], sum_adj[TIME_W-1:1]};
    assign dly_neg  = r_dly[TIME_W-1];

    // The slot being written becomes valid; the ring is full when every
    // slot then holds a sample.
    assign valid_set  = r_valid | ({{(RING_DEPTH-1){1'b0}}, 1'b1} << r_wslot);
    assign ring_full  = &valid_set;
    assign wslot_next = (r_wslot == IDX_W'(RING_DEPTH - 1)) ? '0 : r_wslot + 1'b1;

    // The poll class is taken from the trust level before it rises.
    always_comb begin
        if (r_trust < r_trust_initial) begin
            iclass = CLASS_PATHETIC;
        end else if (r_trust < r_trust_aggressive) begin
            iclass = CLASS_AGGRESSIVE;
        end else begin
            iclass = CLASS_NORMAL;
        end
    end

    // ------------------------------------------------------------------
    // Ring memories. A sample is written in the WRITE state and the scan
    // starts on the following cycle, so the scan never reads a slot whose
    // write is still in flight and no forwarding path is needed.
    // ------------------------------------------------------------------
    assign ring_we.od    = (r_state == ST_WRITE);
    assign ring_we.so    = (r_state == ST_WRITE) && !dly_neg;
    assign ring_od_wdata = '{offset: off_half, delay: r_dly};
    assign ring_so_wdata = '{stratum: r_in.stratum, order: r_arrival};
    assign ring_raddr    = (r_cnt < CNT_W'(RING_DEPTH)) ? r_cnt[IDX_W-1:0] : '0;

    ntpf_ring #(
        .DEPTH (RING_DEPTH),
        .IDX_W (IDX_W)
    ) u_ring (
        .i_clk      (i_clk),
        .i_we       (ring_we),
        .i_waddr    (r_wslot),
        .i_od_wdata (ring_od_wdata),
        .i_so_wdata (ring_so_wdata),
        .i_raddr    (ring_raddr),
        .o_od_rdata (ring_od_rdata),
        .o_so_rdata (ring_so_rdata)
    );

    // ------------------------------------------------------------------
    // Scan. The counter issues read address k while the data of slot k-1
    // arrives, and the scan ends once the data of the last slot is captured. It
    // only runs with a full ring, so every slot read is valid.
    // ------------------------------------------------------------------
    assign scan_ctl.capture = (r_state == ST_SCAN) && (r_cnt != '0);
    assign scan_ctl.first   = (r_cnt == CNT_W'(1));
    assign scan_idx         = IDX_W'(r_cnt - 1'b1);
    assign scan_last        = (r_cnt == CNT_W'(RING_DEPTH));

    ntpf_select #(
        .DEPTH (RING_DEPTH),
        .IDX_W (IDX_W)
    ) u_select (
        .i_clk     (i_clk),
        .i_ctl     (scan_ctl),
        .i_idx     (scan_idx),
        .i_od      (ring_od_rdata),
        .i_so      (ring_so_rdata),
        .o_best_od (best_od),
        .o_best_so (best_so),
        .o_kill    (kill)
    );

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF: begin
                n_state = ((r_in.func == FUNC_REPLY) && reply_ok) ? ST_SUM : ST_DONE;
            end
            ST_SUM:   n_state = ST_WRITE;
            ST_WRITE: n_state = (!dly_neg && ring_full) ? ST_SCAN : ST_DONE;
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_INVAL;
                end
            end
            ST_INVAL: n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control state, configuration and the filter's persistent state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= ST_IDLE;
            r_trust_initial    <= TRUST_INITIAL_RST;
            r_trust_aggressive <= TRUST_AGGRESSIVE_RST;
            r_trust_max        <= TRUST_MAX_RST;
            r_max_stratum      <= MAX_STRATUM_RST;
            r_time_limit       <= TIME_LIMIT_RST;
            r_saved_send       <= '0;
            r_saved_cookie     <= '0;
            r_errs             <= '0;
            r_trust            <= TRUST_INITIAL_RST;
            r_wslot            <= '0;
            r_arrival          <= '0;
            r_valid            <= '0;
            r_cnt              <= '0;
            r_strobe           <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_DONE);

            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_TRUST_INITIAL:    r_trust_initial    <= i_cfg_wdata[TRUST_W-1:0];
                    REG_TRUST_AGGRESSIVE: r_trust_aggressive <= i_cfg_wdata[TRUST_W-1:0];
                    REG_TRUST_MAX:        r_trust_max        <= i_cfg_wdata[TRUST_W-1:0];
                    REG_MAX_STRATUM:      r_max_stratum      <= i_cfg_wdata[STRATUM_W-1:0];
                    REG_TIME_LIMIT:       r_time_limit       <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                ST_DIFF: begin
                    unique case (r_in.func)
                        FUNC_QUERY: begin
                            r_saved_send   <= r_in.local_send_time;
                            r_saved_cookie <= r_in.cookie;
                            r_errs         <= '0;
                        end
                        FUNC_SEND_FAIL: begin
                            if (r_errs != ERRS_MAX) begin
                                r_errs <= r_errs + 1'b1;
                            end
                            r_trust <= r_trust_initial;
                        end
                        FUNC_ADDRESS: begin
                            r_wslot <= '0;
                            r_trust <= r_trust_initial;
                        end
                        FUNC_REPLY: begin
                        end
                    endcase
                end
                ST_WRITE: begin
                    r_cnt <= '0;
                    if (!dly_neg) begin
                        r_valid   <= valid_set;
                        r_arrival <= r_arrival + 1'b1;
                        r_wslot   <= wslot_next;
                        if (r_trust < r_trust_max) begin
                            r_trust <= r_trust + 1'b1;
                        end
                    end
                end
                ST_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                ST_INVAL: begin
                    // When adjust_ok is set, drop the selected sample and every older one.
                    if (r_in.adjust_ok) begin
                        r_valid <= r_valid & ~kill;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers of the transaction in flight.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && start) begin
            r_in      <= i_cmd;
            r_res_off <= '0;
            r_res_dly <= '0;
            r_iclass  <= CLASS_PATHETIC;
            r_upd     <= 1'b0;
        end
        unique case (r_state)
            ST_DIFF: begin
                r_d21     <= r_in.server_recv_time - r_saved_send;
                r_d34     <= r_in.server_send_time - r_in.local_recv_time;
                r_d41     <= r_in.local_recv_time - r_saved_send;
                r_d32     <= r_in.server_send_time - r_in.server_recv_time;
                r_verdict <= diff_verdict;
            end
            ST_SUM: begin
                r_sum <= r_d21 + r_d34;
                r_dly <= r_d41 - r_d32;
            end
            ST_WRITE: begin
                r_res_off <= off_half;
                r_res_dly <= r_dly;
                if (dly_neg) begin
                    r_verdict <= V_NEG_DELAY;
                end else begin
                    r_verdict <= V_ACCEPT;
                    r_iclass  <= iclass;
                end
            end
            ST_INVAL: begin
                r_upd <= 1'b1;
            end
            ST_DONE: begin
                r_out.verdict        <= r_verdict;
                r_out.offset         <= r_res_off;
                r_out.delay          <= r_res_dly;
                r_out.interval_class <= r_iclass;
                r_out.trust          <= r_trust;
                r_out.update_valid   <= r_upd;
                r_out.update_offset  <= r_upd ? best_od.offset : '0;
                r_out.update_delay   <= r_upd ? best_od.delay : '0;
                r_out.update_stratum <= r_upd ? best_so.stratum : '0;
                r_out.send_errors    <= r_errs;
            end
            default: begin
            end
        endcase
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `NTPF_ASSERT_NEXT(a_accept_goes_busy, i_clk, i_rst_n, start && !busy, busy, "accepted transaction did not make the block busy")
    `NTPF_ASSERT_NEXT(a_done_strobes, i_clk, i_rst_n, r_state == ST_DONE, o_strobe, "finished transaction gave no result strobe")
    `NTPF_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe, "result strobe lasted more than one cycle")
    `NTPF_ASSERT_SAME(a_scan_full_ring, i_clk, i_rst_n, r_state == ST_SCAN, &r_valid, "ring scan started with an invalid slot")
    `NTPF_ASSERT_SAME(a_update_accepted, i_clk, i_rst_n, o_strobe && o_result.update_valid, o_result.verdict == V_ACCEPT, "filtered update on a reply that was not accepted")

endmodule

// File: sv/ntpf_ring.sv
// ============================================================================
// ntpf_ring
// Sample ring storage: offset/delay memory and stratum/order memory, one
// write port and one registered read port each.
// ============================================================================
module ntpf_ring #(
    parameter int DEPTH = 8,
    parameter int IDX_W = 3
) (
    input  logic                i_clk,
    input  ntpf_pkg::t_ring_we  i_we,
    input  logic [IDX_W-1:0]    i_waddr,
    input  ntpf_pkg::t_od       i_od_wdata,
    input  ntpf_pkg::t_so       i_so_wdata,
    input  logic [IDX_W-1:0]    i_raddr,
    output ntpf_pkg::t_od       o_od_rdata,
    output ntpf_pkg::t_so       o_so_rdata
);
    import ntpf_pkg::*;

    t_od r_od_mem [DEPTH];
    t_so r_so_mem [DEPTH];
    t_od r_od_rd;
    t_so r_so_rd;

    // A negative-delay sample rewrites only the offset/delay half of a slot.
    always_ff @(posedge i_clk) begin
        if (i_we.od) begin
            r_od_mem[i_waddr] <= i_od_wdata;
        end
        if (i_we.so) begin
            r_so_mem[i_waddr] <= i_so_wdata;
        end
        r_od_rd <= r_od_mem[i_raddr];
        r_so_rd <= r_so_mem[i_raddr];
    end

    assign o_od_rdata = r_od_rd;
    assign o_so_rdata = r_so_rd;

endmodule

// File: sv/ntpf_select.sv
// ============================================================================
// ntpf_select
// Best-sample search over the ring scan and the invalidation mask of the
// selected sample and every older one.
// ============================================================================
module ntpf_select #(
    parameter int DEPTH = 8,
    parameter int IDX_W = 3
) (
    input  logic                i_clk,
    input  ntpf_pkg::t_scan_ctl i_ctl,
    input  logic [IDX_W-1:0]    i_idx,
    input  ntpf_pkg::t_od       i_od,
    input  ntpf_pkg::t_so       i_so,
    output ntpf_pkg::t_od       o_best_od,
    output ntpf_pkg::t_so       o_best_so,
    output logic [DEPTH-1:0]    o_kill
);
    import ntpf_pkg::*;

    t_od                r_best_od;
    t_so                r_best_so;
    logic [ORDER_W-1:0] r_ord [DEPTH];
    logic               take;

    // A later slot wins only when strictly lower in delay at no higher stratum.
    assign take = i_ctl.first ||
                  ((i_so.stratum <= r_best_so.stratum) &&
                   ($signed(i_od.delay) < $signed(r_best_od.delay)));

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_ord[i_idx] <= i_so.order;
            if (take) begin
                r_best_od <= i_od;
                r_best_so <= i_so;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            o_kill[i] = (r_ord[i] <= r_best_so.order);
        end
    end

    assign o_best_od = r_best_od;
    assign o_best_so = r_best_so;

endmodule

// File: verif/ntp_offset_clock_filter_checker.sv
// ============================================================================
// NTP offset clock filter checker
// Watches the command, result and register channels of the filter, keeps its
// own copy of the screening and ring state, and compares every result
// transaction field by field with the oldest prediction.
// ============================================================================
module ntp_offset_clock_filter_checker #(
    parameter int RING_DEPTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  ntpf_pkg::t_cmd                      i_cmd,
    input  logic                                i_strobe,
    input  ntpf_pkg::t_result                   i_result,
    input  logic                                i_cfg_we,
    input  logic [ntpf_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [ntpf_pkg::LIMIT_W-1:0]        i_cfg_wdata,
    output int                                  o_pending,
    output int                                  o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import ntpf_pkg::*;

    localparam int PRINT_CAP = 200;

    logic [TRUST_W-1:0]   cfg_trust_initial;
    logic [TRUST_W-1:0]   cfg_trust_aggressive;
    logic [TRUST_W-1:0]   cfg_trust_max;
    logic [STRATUM_W-1:0] cfg_max_stratum;
    logic [LIMIT_W-1:0]   cfg_time_limit;

    logic [TIME_W-1:0]    ring_offset  [RING_DEPTH];
    logic [TIME_W-1:0]    ring_delay   [RING_DEPTH];
    logic [STRATUM_W-1:0] ring_stratum [RING_DEPTH];
    logic                 ring_valid   [RING_DEPTH];
    logic [ORDER_W-1:0]   ring_order   [RING_DEPTH];
    logic [ORDER_W-1:0]   arrivals;
    int                   slot_ptr;
    logic [TRUST_W-1:0]   trust_now;
    logic [TIME_W-1:0]    query_t1;
    logic [TIME_W-1:0]    query_cookie;
    logic [ERRS_W-1:0]    send_fail_run;

    t_result due_results[$];
    int      mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic reset_filter();
        cfg_trust_initial    = TRUST_INITIAL_RST;
        cfg_trust_aggressive = TRUST_AGGRESSIVE_RST;
        cfg_trust_max        = TRUST_MAX_RST;
        cfg_max_stratum      = MAX_STRATUM_RST;
        cfg_time_limit       = TIME_LIMIT_RST;
        for (int i = 0; i < RING_DEPTH; i++) begin
            ring_offset[i]  = '0;
            ring_delay[i]   = '0;
            ring_stratum[i] = '0;
            ring_valid[i]   = 1'b0;
            ring_order[i]   = '0;
        end
        arrivals      = '0;
        slot_ptr      = 0;
        trust_now     = TRUST_INITIAL_RST;
        query_t1      = '0;
        query_cookie  = '0;
        send_fail_run = '0;
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [LIMIT_W-1:0] data);
        case (idx)
            REG_TRUST_INITIAL:    cfg_trust_initial    = data[TRUST_W-1:0];
            REG_TRUST_AGGRESSIVE: cfg_trust_aggressive = data[TRUST_W-1:0];
            REG_TRUST_MAX:        cfg_trust_max        = data[TRUST_W-1:0];
            REG_MAX_STRATUM:      cfg_max_stratum      = data[STRATUM_W-1:0];
            REG_TIME_LIMIT:       cfg_time_limit       = data;
            default: ;
        endcase
    endtask

    // Screens one event, updates the sample ring and returns its result.
    task automatic screen_and_filter(input t_cmd c, output t_result r);
        logic [TIME_W-1:0]  t1, sum, off, dly, lim;
        logic [ORDER_W-1:0] border;
        int                 slot, best, valid_cnt;
        bit                 have;
        r   = '0;
        t1  = query_t1;
        lim = {1'b0, cfg_time_limit};
        case (c.func)
            FUNC_QUERY: begin
                query_t1      = c.local_send_time;
                query_cookie  = c.cookie;
                send_fail_run = '0;
                r.verdict     = V_QUERY;
            end
            FUNC_SEND_FAIL: begin
                if (send_fail_run != ERRS_MAX)
                    send_fail_run++;
                trust_now = cfg_trust_initial;
                r.verdict = V_SEND_FAIL;
            end
            FUNC_ADDRESS: begin
                slot_ptr  = 0;
                trust_now = cfg_trust_initial;
                r.verdict = V_ADDRESS;
            end
            default: begin
                if (c.cookie != query_cookie) begin
                    r.verdict = V_COOKIE;
                end else if (c.leap == LEAP_ALARM || c.stratum == '0 ||
                             c.stratum > cfg_max_stratum) begin
                    r.verdict = V_UNSYNC;
                end else if ($signed(c.server_recv_time) > $signed(lim) ||
                             $signed(c.server_send_time) > $signed(lim)) begin
                    r.verdict = V_TIME_LIMIT;
                end else if (!($signed(t1) < $signed(c.local_recv_time))) begin
                    r.verdict = V_NONMONO;
                end else begin
                    slot = slot_ptr % RING_DEPTH;
                    sum  = (c.server_recv_time - t1) +
                           (c.server_send_time - c.local_recv_time);
                    // Halve with truncation toward zero.
                    off  = sum[TIME_W-1] ? (64'd0 - ((64'd0 - sum) >> 1)) : (sum >> 1);
                    dly  = (c.local_recv_time - t1) -
                           (c.server_send_time - c.server_recv_time);
                    ring_offset[slot] = off;
                    ring_delay[slot]  = dly;
                    r.offset = off;
                    r.delay  = dly;
                    if (dly[TIME_W-1]) begin
                        r.verdict = V_NEG_DELAY;
                    end else begin
                        ring_stratum[slot] = c.stratum;
                        ring_valid[slot]   = 1'b1;
                        ring_order[slot]   = arrivals;
                        arrivals++;
                        slot_ptr = (slot + 1) % RING_DEPTH;
                        if (trust_now < cfg_trust_initial)
                            r.interval_class = CLASS_PATHETIC;
                        else if (trust_now < cfg_trust_aggressive)
                            r.interval_class = CLASS_AGGRESSIVE;
                        else
                            r.interval_class = CLASS_NORMAL;
                        if (trust_now < cfg_trust_max)
                            trust_now++;
                        valid_cnt = 0;
                        best      = 0;
                        have      = 1'b0;
                        for (int i = 0; i < RING_DEPTH; i++) begin
                            if (ring_valid[i]) begin
                                valid_cnt++;
                                if (!have) begin
                                    best = i;
                                    have = 1'b1;
                                end
                                if (ring_stratum[i] <= ring_stratum[best] &&
                                    $signed(ring_delay[i]) < $signed(ring_delay[best]))
                                    best = i;
                            end
                        end
                        if (valid_cnt >= RING_DEPTH) begin
                            border           = ring_order[best];
                            r.update_valid   = 1'b1;
                            r.update_offset  = ring_offset[best];
                            r.update_delay   = ring_delay[best];
                            r.update_stratum = ring_stratum[best];
                            if (c.adjust_ok)
                                for (int i = 0; i < RING_DEPTH; i++)
                                    if (ring_order[i] <= border)
                                        ring_valid[i] = 1'b0;
                        end
                        r.verdict = V_ACCEPT;
                    end
                end
            end
        endcase
        r.trust       = trust_now;
        r.send_errors = send_fail_run;
    endtask

    task automatic compare_result(input t_result got, input t_result want);
        if (got.verdict !== want.verdict)
            report_mismatch("verdict", got.verdict, want.verdict);
        if (got.offset !== want.offset)
            report_mismatch("offset", got.offset, want.offset);
        if (got.delay !== want.delay)
            report_mismatch("delay", got.delay, want.delay);
        if (got.interval_class !== want.interval_class)
            report_mismatch("interval_class", got.interval_class, want.interval_class);
        if (got.trust !== want.trust)
            report_mismatch("trust", got.trust, want.trust);
        if (got.update_valid !== want.update_valid)
            report_mismatch("update_valid", got.update_valid, want.update_valid);
        if (got.update_offset !== want.update_offset)
            report_mismatch("update_offset", got.update_offset, want.update_offset);
        if (got.update_delay !== want.update_delay)
            report_mismatch("update_delay", got.update_delay, want.update_delay);
        if (got.update_stratum !== want.update_stratum)
            report_mismatch("update_stratum", got.update_stratum, want.update_stratum);
        if (got.send_errors !== want.send_errors)
            report_mismatch("send_errors", got.send_errors, want.send_errors);
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            reset_filter();
            due_results.delete();
        end else begin
            // A result never belongs to a transaction accepted at the same edge,
            // so the result side is handled first.
            if ($isunknown(i_strobe)) begin
                report_mismatch("strobe unknown", i_strobe, 1'b0);
            end else if (i_strobe) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result with nothing expected", i_result.verdict, '0);
                end else begin
                    want = due_results.pop_front();
                    compare_result(i_result, want);
                end
            end
            if (i_cfg_we)
                apply_register(i_cfg_addr, i_cfg_wdata);
            if (i_start && !i_busy) begin
                screen_and_filter(i_cmd, want);
                due_results.push_back(want);
            end
        end
        o_pending = due_results.size();
    end

endmodule

// File: verif/tb_ntp_offset_clock_filter.sv
// ============================================================================
// NTP offset clock filter testbench
// Drives query, reply, send-failure and address-change transactions into the
// filter, first a short directed list, then random traffic under several
// register settings. A checker beside the block predicts and compares every
// result.
// ============================================================================
module tb_ntp_offset_clock_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import ntpf_pkg::*;

    localparam int RING_DEPTH   = 8;
    // About 720 transactions, the longest of them a full-ring scan, plus the idle
    // bursts between them come to a total that the limit exceeds by a wide margin.
    localparam int CYCLE_LIMIT  = 200_000;
    // The longest transaction is one with a full-ring scan.
    localparam int DRAIN_CYCLES = RING_DEPTH + 12;

    localparam logic [TIME_W-1:0] TIME_MIN = 64'h8000_0000_0000_0000;
    localparam logic [TIME_W-1:0] TIME_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    // Keeps the query time far enough below the time limit that a normal
    // exchange trips the limit check only if its server times wrap around.
    localparam longint SKEW_SPAN = longint'(1) << 41;

    // Ways to spoil an otherwise well-formed exchange.
    typedef enum int {
        BREAK_COOKIE,
        BREAK_LEAP,
        BREAK_STRATUM_ZERO,
        BREAK_STRATUM_HIGH,
        BREAK_TIME_LIMIT,
        BREAK_NONMONO,
        BREAK_NEG_DELAY
    } t_fault;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_cmd                 i_cmd       = '0;
    logic                 o_strobe;
    t_result              o_result;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr  = '0;
    logic [LIMIT_W-1:0]   i_cfg_wdata = '0;

    int pending;
    int mismatches;
    int cycle_count = 0;
    int issued      = 0;

    // Copies of the screening registers, used only to shape the stimulus.
    logic [STRATUM_W-1:0] stim_max_stratum = MAX_STRATUM_RST;
    logic [LIMIT_W-1:0]   stim_time_limit  = TIME_LIMIT_RST;
    bit                   gaps_on          = 1'b1;

    always #5 i_clk = ~i_clk;

    ntp_offset_clock_filter #(
        .RING_DEPTH (RING_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    ntp_offset_clock_filter_checker #(
        .RING_DEPTH (RING_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // A transaction with every field random; callers override what matters.
    function automatic t_cmd noise_cmd();
        t_cmd c;
        c.func             = 2'($urandom);
        c.local_send_time  = rand64();
        c.cookie           = rand64();
        c.server_recv_time = rand64();
        c.server_send_time = rand64();
        c.local_recv_time  = rand64();
        c.leap             = 2'($urandom);
        c.stratum          = 8'($urandom);
        c.adjust_ok        = 1'($urandom);
        return c;
    endfunction

    // Presents one transaction and holds it until the block takes it. Inputs
    // change on the falling edge; busy is read right after the rising edge, so
    // it still shows the value the block saw at that edge. Start is left high
    // afterwards so that a following transaction can go out without a bubble.
    task automatic issue(input t_cmd c);
        if (gaps_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 10)) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        issued++;
    endtask

    // Lowers start and holds off until every predicted result has been seen.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic event_only(input logic [1:0] f);
        t_cmd c;
        c      = noise_cmd();
        c.func = f;
        issue(c);
    endtask

    task automatic query(input logic [63:0] t1, input logic [63:0] key);
        t_cmd c;
        c                 = noise_cmd();
        c.func            = FUNC_QUERY;
        c.local_send_time = t1;
        c.cookie          = key;
        issue(c);
    endtask

    task automatic reply(input logic [63:0] key, input logic [63:0] t2,
                         input logic [63:0] t3, input logic [63:0] t4,
                         input logic [1:0] leap, input logic [7:0] strat,
                         input logic adj);
        t_cmd c;
        c                  = noise_cmd();
        c.func             = FUNC_REPLY;
        c.cookie           = key;
        c.server_recv_time = t2;
        c.server_send_time = t3;
        c.local_recv_time  = t4;
        c.leap             = leap;
        c.stratum          = strat;
        c.adjust_ok        = adj;
        issue(c);
    endtask

    // A register write carries random bits above the register's width, which
    // the block must drop.
    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [LIMIT_W-1:0] value, input int width);
        logic [LIMIT_W-1:0] keep;
        keep = (63'd1 << width) - 63'd1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= (63'(rand64()) & ~keep) | (value & keep);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Writes all five registers, then one of the indexes past the end with
    // junk, which must leave every register alone.
    task automatic apply_settings(input logic [3:0] ti, input logic [3:0] ta,
                                  input logic [3:0] tm, input logic [7:0] ms,
                                  input logic [LIMIT_W-1:0] tl);
        program_reg(REG_TRUST_INITIAL, 63'(ti), TRUST_W);
        program_reg(REG_TRUST_AGGRESSIVE, 63'(ta), TRUST_W);
        program_reg(REG_TRUST_MAX, 63'(tm), TRUST_W);
        program_reg(REG_MAX_STRATUM, 63'(ms), STRATUM_W);
        program_reg(REG_TIME_LIMIT, tl, LIMIT_W);
        program_reg(REG_TIME_LIMIT + 3'($urandom_range(1, 3)), 63'(rand64()), LIMIT_W);
        stim_max_stratum = ms;
        stim_time_limit  = tl;
    endtask

    // Query send times spread over the whole range, with the ends and the
    // neighborhood of zero favored.
    function automatic logic [63:0] pick_time();
        case ($urandom_range(0, 3))
            0:       return rand64();
            1:       return 64'($signed(rand64()) >>> 32);
            2:       return TIME_MAX - 64'($urandom);
            default: return TIME_MIN + 64'($urandom);
        endcase
    endfunction

    // One query followed by one or two replies that carry its cookie. The
    // server times sit close to the query time, and the round trip is short
    // enough that equal delays are common, which exercises the tie rule of
    // the best-sample pick. A broken exchange spoils exactly one screening
    // condition of the reply.
    task automatic exchange(input bit broken);
        logic signed [63:0] t1, t2, t3, t4, lim, fwd;
        logic [63:0]        key, reply_key;
        int unsigned        proc, extra;
        logic [1:0]         leap;
        logic [7:0]         strat;
        logic               adj;
        t_fault             fault;
        int                 replies;
        lim = $signed({1'b0, stim_time_limit});
        t1  = pick_time();
        if (t1 > lim - SKEW_SPAN)
            t1 = lim - SKEW_SPAN - 64'($urandom);
        fwd   = $signed(rand64()) >>> $urandom_range(23, 63);
        proc  = $urandom_range(0, 2000);
        extra = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7)
                                            : $urandom_range(0, 1 << 20);
        t2    = t1 + fwd;
        t3    = t2 + proc;
        t4    = t1 + proc + extra;
        key   = rand64();
        reply_key = key;
        leap  = 2'($urandom_range(0, 2));
        if (stim_max_stratum > 8'd4 && $urandom_range(0, 1) == 0)
            strat = 8'($urandom_range(1, 4));
        else
            strat = 8'($urandom_range(1, stim_max_stratum));
        adj = ($urandom_range(0, 2) == 0);
        if (broken) begin
            fault = t_fault'($urandom_range(BREAK_COOKIE, BREAK_NEG_DELAY));
            case (fault)
                BREAK_COOKIE:       reply_key = key ^ (64'd1 << $urandom_range(0, 63));
                BREAK_LEAP:         leap = LEAP_ALARM;
                BREAK_STRATUM_ZERO: strat = 8'd0;
                BREAK_STRATUM_HIGH: strat = (stim_max_stratum == 8'hFF) ? 8'd0 :
                                    8'($urandom_range(stim_max_stratum + 1, 255));
                BREAK_TIME_LIMIT: begin
                    if ($urandom_range(0, 1) == 0)
                        t2 = lim + 1 + $urandom_range(0, 1000);
                    else
                        t3 = lim + 1 + $urandom_range(0, 1000);
                end
                BREAK_NONMONO:      t4 = t1 - $urandom_range(0, 1000);
                default: begin
                    // Server hold time longer than the whole round trip.
                    proc = proc + 4;
                    t3   = t2 + proc;
                    t4   = t1 + 1 + $urandom_range(0, proc - 2);
                end
            endcase
        end
        query(t1, key);
        replies = ($urandom_range(0, 7) == 0) ? 2 : 1;
        repeat (replies) reply(reply_key, t2, t3, t4, leap, strat, adj);
    endtask

    // Random traffic: mostly well-formed exchanges, the rest broken exchanges,
    // pure noise, send failures, address changes and an occasional full drain
    // while idle cycles are allowed.
    task automatic run_traffic(input int n);
        int goal;
        int pick;
        goal = issued + n;
        while (issued < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                exchange(1'b0);
            else if (pick < 84)
                exchange(1'b1);
            else if (pick < 90)
                issue(noise_cmd());
            else if (pick < 93)
                event_only(FUNC_SEND_FAIL);
            else if (pick < 97)
                event_only(FUNC_ADDRESS);
            else if (gaps_on)
                drain();
        end
    endtask

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_ntp_offset_clock_filter failed");
        $finish;
    end

    initial begin : stimulus
        logic [63:0]  key;
        int unsigned  fill_delay [7];
        logic [7:0]   fill_stratum [7];
        fill_delay   = '{30, 7, 7, 500, 3, 3, 90};
        fill_stratum = '{8'd2, 8'd1, 8'd1, 8'd3, 8'd2, 8'd1, 8'd15};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, run with the register values from reset.
        // A reply before any query is checked against the cleared cookie and
        // a send time of zero; a nonzero cookie is then a mismatch.
        reply(64'd0, 64'd10, 64'd20, 64'd50, 2'd0, 8'd1, 1'b0);
        reply(64'd1, 64'd10, 64'd20, 64'd50, 2'd0, 8'd1, 1'b0);
        // Query at the most negative time, cookie all ones.
        query(TIME_MIN, '1);
        reply(64'hFFFF_FFFF_FFFF_FFFE, 64'd0, 64'd0, 64'd5, 2'd0, 8'd1, 1'b0);
        reply('1, 64'd0, 64'd0, 64'd5, LEAP_ALARM, 8'd1, 1'b0);
        reply('1, 64'd0, 64'd0, 64'd5, 2'd0, 8'd0, 1'b0);
        reply('1, 64'd0, 64'd0, 64'd5, 2'd0, 8'd255, 1'b0);
        // Local receive time equal to the send time.
        reply('1, 64'd0, 64'd0, TIME_MIN, 2'd0, 8'd1, 1'b0);
        // Offset sum wraps and the odd negative sum is halved toward zero;
        // stratum right at the ceiling.
        reply('1, TIME_MAX, TIME_MAX, TIME_MIN + 64'd1, 2'd2, 8'd15, 1'b0);
        // Negative delay: the slot's offset and delay are overwritten while the
        // write position and trust stay.
        reply('1, 64'd0, 64'd100, TIME_MIN + 64'd10, 2'd1, 8'd1, 1'b0);
        // Fill the rest of the ring. The sixth of these completes it and gives
        // the first filtered update; the seventh allows invalidation.
        key = rand64();
        query(64'd1000, key);
        for (int i = 0; i < 7; i++)
            reply(key, 64'd1005, 64'd1005, 64'd1000 + fill_delay[i], 2'd0,
                  fill_stratum[i], i == 6);
        event_only(FUNC_SEND_FAIL);
        // An address change keeps the samples but restarts at slot zero.
        event_only(FUNC_ADDRESS);
        reply(key, 64'd1005, 64'd1005, 64'd1001, 2'd1, 8'd4, 1'b1);
        query(rand64(), rand64());

        // Random traffic under several register settings. Registers are only
        // written once every pending transaction has produced its result.
        run_traffic(140);
        drain();
        apply_settings(4'd0, 4'd0, 4'd0, 8'd1, 63'd0);
        run_traffic(140);
        drain();
        apply_settings(4'd15, 4'd15, 4'd15, 8'd255, TIME_MAX[LIMIT_W-1:0]);
        run_traffic(140);
        drain();
        apply_settings(4'd5, 4'd9, 4'd12, 8'd4, 63'(rand64() >> 20));
        run_traffic(140);
        drain();
        // Last stretch runs back to back, with no idle cycles on the sender.
        apply_settings(4'd8, 4'd3, 4'd6, 8'd200, 63'h4000_0000_0000_0000);
        gaps_on = 1'b0;
        run_traffic(140);

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_ntp_offset_clock_filter passed");
        else
            $display("tb_ntp_offset_clock_filter failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/ntpf_pkg.sv
sv/ntpf_ring.sv
sv/ntpf_select.sv
sv/ntp_offset_clock_filter.sv
verif/ntp_offset_clock_filter_checker.sv
verif/tb_ntp_offset_clock_filter.sv
